[hdl/cfs_pkg.sv]
// shared constants, types and helper functions of the coil frame scanner
`default_nettype none

package cfs_pkg;

  // frame geometry
  localparam int COLUMNS    = 17;
  localparam int ROWS       = 6;
  localparam int ROWS_HALF  = (ROWS + 1) / 2;
  localparam int BANK_DEPTH = COLUMNS * ROWS_HALF;
  localparam int ADDR_W     = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS  = 2;

  // field widths
  localparam int COL_W   = 5;
  localparam int ROW_W   = 3;
  localparam int LVL_W   = 4;
  localparam int CODE_W  = 3;
  localparam int WORD_W  = 2 * CODE_W;
  localparam int POWER_W = 14;
  localparam int GAP_W   = 8;
  localparam int CFG_W   = 14;
  localparam int IDX_W   = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_POWER_LIMIT = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_GAP   = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAP_EXTRA   = 2'd2;

  // register reset values
  localparam logic [POWER_W-1:0] POWER_LIMIT_RST = 14'd6000;
  localparam logic [6:0]         FRAME_GAP_RST   = 7'd70;

  // request modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_FRAME = 2'd2;

  // pixel coding and budget
  localparam logic signed [4:0]  LVL_HI      = 5'sd3;
  localparam logic signed [4:0]  LVL_LO      = -5'sd3;
  localparam int                 POWER_SCALE = 10;
  localparam logic [POWER_W:0]   POWER_MAX   = 15'd16383;
  localparam logic [CODE_W-1:0]  NONNEG_BIT  = 3'(1 << 2);

  // store reset pattern: columns three to five hold -2
  localparam int                     RST_COL_LO = 3;
  localparam int                     RST_COL_HI = 5;
  localparam logic signed [LVL_W-1:0] RST_LEVEL = -4'sd2;

  // polarity rom, bit r set means row r is inverted
  localparam int ROM_COLS = 17;
  localparam int ROM_ROWS = 6;
  localparam int ROM_CW   = $clog2(ROM_COLS);
  localparam int ROM_RW   = $clog2(ROM_ROWS);
  localparam logic [ROM_ROWS-1:0] POL_NEG [ROM_COLS] = '{
    6'b101100, 6'b110010, 6'b100010, 6'b101000, 6'b110010, 6'b001101,
    6'b011111, 6'b110111, 6'b110110, 6'b111001, 6'b010011, 6'b011001,
    6'b111100, 6'b011110, 6'b011101, 6'b100110, 6'b011111
  };

  // scan operation carried to the coding stage
  typedef enum logic [1:0] {
    OP_IDLE,
    OP_GAP,
    OP_SEND
  } op_e;

  // frame store write request
  typedef struct packed {
    logic                    en;
    logic                    bank;
    logic [ADDR_W-1:0]       addr;
    logic signed [LVL_W-1:0] value;
  } cfs_wr_t;

  // frame store read request, both banks at one address
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } cfs_rd_req_t;

  // frame store read data
  typedef struct packed {
    logic signed [LVL_W-1:0] lvl_even;
    logic signed [LVL_W-1:0] lvl_odd;
    logic                    vld_even;
    logic                    vld_odd;
  } cfs_rd_t;

  // result of coding one pixel against the budget
  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic [CODE_W-1:0]  code;
  } pix_res_t;

  // bank address of a column and row pair
  function automatic logic [ADDR_W-1:0] bank_addr(logic [COL_W-1:0] col,
                                                  logic [ROW_W-1:0] row);
    return ADDR_W'(int'(col) * ROWS_HALF + int'(row >> 1));
  endfunction

  // level of an entry never written since reset
  function automatic logic signed [LVL_W-1:0] reset_level(logic [COL_W-1:0] col);
    if (int'(col) >= RST_COL_LO && int'(col) <= RST_COL_HI && int'(col) < COLUMNS)
      return RST_LEVEL;
    return '0;
  endfunction

  // polarity lookup, positive outside the rom
  function automatic logic pol_neg(logic [COL_W-1:0] col, logic [ROW_W:0] row);
    if (int'(col) < ROM_COLS && int'(row) < ROM_ROWS)
      return POL_NEG[col[ROM_CW-1:0]][row[ROM_RW-1:0]];
    return 1'b0;
  endfunction

  // apply polarity and clamp to the coil range
  function automatic logic signed [CODE_W-1:0] clamp_lvl(logic signed [LVL_W-1:0] lvl,
                                                         logic neg);
    logic signed [4:0] v;
    v = $signed({lvl[LVL_W-1], lvl});
    if (neg) v = -v;
    if (v > LVL_HI) return LVL_HI[CODE_W-1:0];
    if (v < LVL_LO) return LVL_LO[CODE_W-1:0];
    return v[CODE_W-1:0];
  endfunction

  // power cost of one pixel of a given magnitude
  function automatic logic [6:0] power_cost(logic [1:0] mag);
    return 7'(int'(mag) * int'(mag) * POWER_SCALE);
  endfunction

  // code one clamped pixel and charge the budget
  function automatic pix_res_t code_pixel(logic [POWER_W-1:0] power,
                                          logic [POWER_W-1:0] limit,
                                          logic signed [CODE_W-1:0] v);
    pix_res_t          res;
    logic [CODE_W-1:0] a;
    logic [1:0]        mag;
    logic [POWER_W:0]  sum;
    a   = v[CODE_W-1] ? 3'(-v) : 3'(v);
    mag = a[1:0];
    sum = {1'b0, power} + 15'(power_cost(mag));
    if (power < limit) begin
      res.power = (sum > POWER_MAX) ? POWER_MAX[POWER_W-1:0] : sum[POWER_W-1:0];
      res.code  = v[CODE_W-1] ? {1'b0, mag} : (NONNEG_BIT | {1'b0, mag});
    end else begin
      res.power = power;
      res.code  = NONNEG_BIT;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/cfs_frame_mem.sv]
// two-bank frame store with registered reads and per-entry valid bits
`default_nettype none

module cfs_frame_mem (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfs_pkg::cfs_wr_t     wr_i,
  input  wire cfs_pkg::cfs_rd_req_t rd_i,
  output cfs_pkg::cfs_rd_t          rd_o
);

  // even rows in bank 0, odd rows in bank 1
  logic signed [cfs_pkg::LVL_W-1:0] frame_mem [cfs_pkg::NUM_BANKS][cfs_pkg::BANK_DEPTH];
  logic [cfs_pkg::BANK_DEPTH-1:0]   vld_even_q;
  logic [cfs_pkg::BANK_DEPTH-1:0]   vld_odd_q;
  logic signed [cfs_pkg::LVL_W-1:0] rdata_even_q;
  logic signed [cfs_pkg::LVL_W-1:0] rdata_odd_q;
  logic                             rvld_even_q;
  logic                             rvld_odd_q;

  // memory write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      frame_mem[wr_i.bank][wr_i.addr] <= wr_i.value;
    end
    if (rd_i.en) begin
      rdata_even_q <= frame_mem[0][rd_i.addr];
      rdata_odd_q  <= frame_mem[1][rd_i.addr];
    end
  end

  // valid bits, cleared at reset so unwritten entries read the reset pattern
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_even_q  <= '0;
      vld_odd_q   <= '0;
      rvld_even_q <= 1'b0;
      rvld_odd_q  <= 1'b0;
    end else begin
      if (wr_i.en && !wr_i.bank) vld_even_q[wr_i.addr] <= 1'b1;
      if (wr_i.en && wr_i.bank)  vld_odd_q[wr_i.addr]  <= 1'b1;
      if (rd_i.en) begin
        rvld_even_q <= vld_even_q[rd_i.addr];
        rvld_odd_q  <= vld_odd_q[rd_i.addr];
      end
    end
  end

  // read data out
  assign rd_o.lvl_even = rdata_even_q;
  assign rd_o.lvl_odd  = rdata_odd_q;
  assign rd_o.vld_even = rvld_even_q;
  assign rd_o.vld_odd  = rvld_odd_q;

endmodule

`default_nettype wire

[hdl/coil_frame_scanner_core.sv]
// top level of the coil frame scanner: scan control, pixel coding and result register
// a tick request is registered in the coding stage, then in the result register
// throughput: one request per cycle unless in_stall_o is high; the frame store reads
//   a row pair in one access; the coding stage updates the budget once per cycle
// reset: control state and config registers reset at once, payload registers do not;
//   the frame store valid bits clear so unwritten entries read the reset pattern
// no clearing pass follows reset, requests are taken from the first cycle
`default_nettype none

module coil_frame_scanner_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic [cfs_pkg::COL_W-1:0]    pixel_col_i,
  input  wire logic [cfs_pkg::ROW_W-1:0]    pixel_row_i,
  input  wire logic signed [cfs_pkg::LVL_W-1:0] pixel_value_i,
  input  wire logic                         link_ready_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [cfs_pkg::WORD_W-1:0]        coil_word_o,
  output logic                              word_sent_o,
  output logic                              frame_done_o,
  // configuration port
  input  wire logic                         cfg_we_i,
  input  wire logic [cfs_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [cfs_pkg::CFG_W-1:0]    cfg_wdata_i
);

  typedef struct packed {
    cfs_pkg::op_e              op;
    logic [cfs_pkg::COL_W-1:0] col;
    logic [cfs_pkg::ROW_W-1:0] row;
    logic                      done;
  } stage_t;

  logic [cfs_pkg::POWER_W-1:0] power_limit_q;
  logic [6:0]                  frame_gap_q;
  logic                        gap_extra_q;

  logic [cfs_pkg::GAP_W-1:0]   gap_cnt_q, gap_cnt_d;
  logic [cfs_pkg::COL_W-1:0]   scan_col_q, scan_col_d;
  logic [cfs_pkg::ROW_W-1:0]   scan_row_q, scan_row_d;
  logic                        pending_q, pending_d;
  logic [cfs_pkg::POWER_W-1:0] power_q, power_d;

  logic                        s2_vld_q, s2_vld_d;
  stage_t                      s2_q, s2_d;
  logic                        out_vld_q, out_vld_d;
  logic [cfs_pkg::WORD_W-1:0]  word_q, word_d;
  logic                        sent_q, sent_d;
  logic                        done_q, done_d;

  logic                        out_free;
  logic                        s2_adv;
  logic                        in_acc;
  logic [cfs_pkg::ROW_W:0]     row_next;
  logic [cfs_pkg::ROW_W:0]     row_second;
  logic signed [cfs_pkg::LVL_W-1:0] lvl0, lvl1;
  cfs_pkg::pix_res_t           pix0, pix1;

  cfs_pkg::cfs_wr_t            mem_wr;
  cfs_pkg::cfs_rd_req_t        mem_rd;
  cfs_pkg::cfs_rd_t            mem_rdata;

  // handshake: the coding stage holds only while the result register is blocked
  assign out_free   = !out_vld_q || !out_stall_i;
  assign s2_adv     = s2_vld_q && out_free;
  assign in_stall_o = s2_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_limit_q <= cfs_pkg::POWER_LIMIT_RST;
      frame_gap_q   <= cfs_pkg::FRAME_GAP_RST;
      gap_extra_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cfs_pkg::REG_POWER_LIMIT: power_limit_q <= cfg_wdata_i[cfs_pkg::POWER_W-1:0];
        cfs_pkg::REG_FRAME_GAP:   frame_gap_q   <= cfg_wdata_i[6:0];
        cfs_pkg::REG_GAP_EXTRA:   gap_extra_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // frame store
  cfs_frame_mem u_frame_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (mem_wr),
    .rd_i   (mem_rd),
    .rd_o   (mem_rdata)
  );

  // scan control: decode request, issue store access, advance scan position
  always_comb begin
    gap_cnt_d  = gap_cnt_q;
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    pending_d  = pending_q;
    s2_d       = s2_q;
    s2_vld_d   = s2_vld_q && !s2_adv;
    row_next   = {1'b0, scan_row_q} + 4'd2;

    mem_wr.en    = 1'b0;
    mem_wr.bank  = pixel_row_i[0];
    mem_wr.addr  = cfs_pkg::bank_addr(pixel_col_i, pixel_row_i);
    mem_wr.value = pixel_value_i;
    mem_rd.en    = 1'b0;
    mem_rd.addr  = cfs_pkg::bank_addr(scan_col_q, scan_row_q);

    if (in_acc) begin
      unique case (mode_i)
        cfs_pkg::MODE_WRITE: begin
          mem_wr.en = (int'(pixel_col_i) < cfs_pkg::COLUMNS) &&
                      (int'(pixel_row_i) < cfs_pkg::ROWS);
        end
        cfs_pkg::MODE_FRAME: begin
          pending_d = 1'b1;
        end
        cfs_pkg::MODE_TICK: begin
          s2_vld_d  = 1'b1;
          s2_d.col  = scan_col_q;
          s2_d.row  = scan_row_q;
          s2_d.done = 1'b0;
          if (gap_cnt_q != '0) begin
            gap_cnt_d = gap_cnt_q - 8'd1;
            s2_d.op   = cfs_pkg::OP_GAP;
          end else if (pending_q && link_ready_i) begin
            s2_d.op   = cfs_pkg::OP_SEND;
            mem_rd.en = 1'b1;
            if (int'(row_next) >= cfs_pkg::ROWS) begin
              scan_row_d = '0;
              if (int'(scan_col_q) + 1 >= cfs_pkg::COLUMNS) begin
                scan_col_d = '0;
                gap_cnt_d  = {1'b0, frame_gap_q} + {7'd0, gap_extra_q};
                pending_d  = 1'b0;
                s2_d.done  = 1'b1;
              end else begin
                scan_col_d = scan_col_q + 5'd1;
              end
            end else begin
              scan_row_d = row_next[cfs_pkg::ROW_W-1:0];
            end
          end else begin
            s2_d.op = cfs_pkg::OP_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  // coding stage: resolve levels, apply polarity and budget, fill result register
  always_comb begin
    row_second = {1'b0, s2_q.row} + 4'd1;
    lvl0 = mem_rdata.vld_even ? mem_rdata.lvl_even : cfs_pkg::reset_level(s2_q.col);
    if (int'(row_second) >= cfs_pkg::ROWS) begin
      lvl1 = '0;
    end else begin
      lvl1 = mem_rdata.vld_odd ? mem_rdata.lvl_odd : cfs_pkg::reset_level(s2_q.col);
    end
    pix0 = cfs_pkg::code_pixel(power_q, power_limit_q,
             cfs_pkg::clamp_lvl(lvl0, cfs_pkg::pol_neg(s2_q.col, {1'b0, s2_q.row})));
    pix1 = cfs_pkg::code_pixel(pix0.power, power_limit_q,
             cfs_pkg::clamp_lvl(lvl1, cfs_pkg::pol_neg(s2_q.col, row_second)));

    power_d   = power_q;
    out_vld_d = out_vld_q && !(!out_stall_i);
    word_d    = word_q;
    sent_d    = sent_q;
    done_d    = done_q;
    if (s2_adv) begin
      out_vld_d = 1'b1;
      word_d    = '0;
      sent_d    = 1'b0;
      done_d    = 1'b0;
      case (s2_q.op)
        cfs_pkg::OP_GAP: begin
          power_d = '0;
        end
        cfs_pkg::OP_SEND: begin
          power_d = pix1.power;
          word_d  = {pix0.code, pix1.code};
          sent_d  = 1'b1;
          done_d  = s2_q.done;
        end
        default: ;
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_cnt_q  <= '0;
      scan_col_q <= '0;
      scan_row_q <= '0;
      pending_q  <= 1'b1;
      power_q    <= '0;
      s2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      gap_cnt_q  <= gap_cnt_d;
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      pending_q  <= pending_d;
      power_q    <= power_d;
      s2_vld_q   <= s2_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s2_q   <= s2_d;
    word_q <= word_d;
    sent_q <= sent_d;
    done_q <= done_d;
  end

  assign out_valid_o  = out_vld_q;
  assign coil_word_o  = word_q;
  assign word_sent_o  = sent_q;
  assign frame_done_o = done_q;

  // stall toward the request side comes only from a held coding stage
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s2_vld_q)
    else $error("request stalled with empty coding stage");

  // a held coding stage keeps its operation
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !s2_adv) |=> (s2_vld_q && $stable(s2_q)))
    else $error("coding stage changed while held");

  // end of frame only on a transmitted word
  a_done_sent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> word_sent_o)
    else $error("frame done without a word sent");

  // scan position stays on an even row inside the frame
  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |-> (!scan_row_q[0] && int'(scan_col_q) < cfs_pkg::COLUMNS))
    else $error("scan position out of frame");

endmodule

`default_nettype wire
